// ===== design/tga_pkg.sv =====
// Package for the Targa run-length pixel decoder: formats, register indexes,
// request kinds and the word passed from front to back end. No dependencies.
`timescale 1ns / 1ps
package tga_pkg;
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] FMT_INDEX8  = 3'd0;
   localparam logic [2:0] FMT_RGB555  = 3'd1;
   localparam logic [2:0] FMT_BGR24   = 3'd2;
   localparam logic [2:0] FMT_BGRA32  = 3'd3;
   localparam logic [2:0] FMT_GRAY8   = 3'd4;
   localparam logic [2:0] FMT_GRAY16  = 3'd5;

   localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] REG_RUN_LENGTH   = 2'd1;
   localparam logic [1:0] REG_TOTAL_PIXELS = 2'd2;

   localparam logic REQ_STREAM  = 1'b0;
   localparam logic REQ_PALETTE = 1'b1;

   // One assembled pixel handed to the back end.
   typedef struct packed {
      logic [2:0]  fmt;
      logic [31:0] bytes;     // byte k at bits 8k+7:8k
      logic [7:0]  reps;
      logic        done;
   } pix_word_type;
endpackage

// ===== design/tga_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module tga_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== design/tga_front.sv =====
// Front end: packet headers, byte gathering, repeat clamping and pixel count.
// Depends on tga_pkg.
`timescale 1ns / 1ps
module tga_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   input  logic [2:0]            pixel_format,
   input  logic                  run_length_coded,
   input  logic [31:0]           total_pixels,
   input  logic                  restart,
   output logic                  pix_valid,
   output tga_pkg::pix_word_type pix_word
);
   logic        in_packet_ff, in_packet_in;
   logic        is_run_ff, is_run_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] gath_ff, gath_in;
   logic [31:0] remain_ff, remain_in;
   logic        loaded_ff, loaded_in;
   logic [2:0]  need;
   logic [31:0] remain_now;
   logic [7:0]  reps;
   logic [7:0]  left_next;
   logic [31:0] bytes;

   always_comb begin
      case (pixel_format)
         tga_pkg::FMT_RGB555: need = 3'd2;
         tga_pkg::FMT_BGR24:  need = 3'd3;
         tga_pkg::FMT_BGRA32: need = 3'd4;
         tga_pkg::FMT_GRAY16: need = 3'd2;
         default:             need = 3'd1;
      endcase
   end

   always_comb begin
      in_packet_in = in_packet_ff;
      is_run_in    = is_run_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      gath_in      = gath_ff;
      remain_in    = remain_ff;
      loaded_in    = loaded_ff;
      pix_valid    = 1'b0;
      reps         = 8'd1;
      left_next    = left_ff;
      remain_now   = loaded_ff ? remain_ff : total_pixels;
      bytes        = {gath_ff[7:0], gath_ff};
      case (pos_ff)
         2'd0: bytes[7:0]   = byte_data;
         2'd1: bytes[15:8]  = byte_data;
         2'd2: bytes[23:16] = byte_data;
         default: bytes[31:24] = byte_data;
      endcase
      if (restart) begin
         in_packet_in = 1'b0; is_run_in = 1'b0; left_in = 8'd0; pos_in = 2'd0;
         gath_in = 24'd0; remain_in = 32'd0; loaded_in = 1'b0;
      end else if (byte_valid && pixel_format <= tga_pkg::FMT_GRAY16) begin
         loaded_in = 1'b1;
         remain_in = remain_now;
         if (remain_now != 32'd0) begin
            if (run_length_coded && !in_packet_ff) begin
               is_run_in    = byte_data[7];
               left_in      = {1'b0, byte_data[6:0]} + 8'd1;
               in_packet_in = 1'b1;
               pos_in       = 2'd0;
               gath_in      = 24'd0;
            end else if ({1'b0, pos_ff} + 3'd1 < need) begin
               gath_in = bytes[23:0];
               pos_in  = pos_ff + 2'd1;
            end else begin
               pos_in  = 2'd0;
               gath_in = 24'd0;
               if (run_length_coded) begin
                  if (is_run_ff) begin
                     reps = left_ff; left_next = 8'd0;
                  end else if (left_ff != 8'd0) begin
                     left_next = left_ff - 8'd1;
                  end
                  left_in = left_next;
                  if (left_next == 8'd0) in_packet_in = 1'b0;
               end
               if (reps == 8'd0) reps = 8'd1;
               if ({24'd0, reps} > remain_now) reps = remain_now[7:0];
               remain_in = remain_now - {24'd0, reps};
               pix_valid = 1'b1;
            end
         end
      end
      pix_word.fmt   = pixel_format;
      pix_word.bytes = bytes;
      pix_word.reps  = reps;
      pix_word.done  = (remain_in == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0; is_run_ff <= 1'b0; left_ff <= 8'd0; pos_ff <= 2'd0;
         gath_ff <= 24'd0; remain_ff <= 32'd0; loaded_ff <= 1'b0;
      end else begin
         in_packet_ff <= in_packet_in; is_run_ff <= is_run_in; left_ff <= left_in;
         pos_ff <= pos_in; gath_ff <= gath_in; remain_ff <= remain_in;
         loaded_ff <= loaded_in;
      end
   end
endmodule

// ===== design/tga_back.sv =====
// Back end: palette lookup and colour expansion, with a small result queue.
// Depends on tga_pkg and tga_ram.
`timescale 1ns / 1ps
module tga_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pix_valid,
   input  tga_pkg::pix_word_type pix_word,
   input  logic                  pal_we,
   input  logic [7:0]            pal_index,
   input  logic [23:0]           pal_data,
   input  logic                  pop,
   output logic                  empty,
   output logic                  no_room,
   output logic [7:0]            red,
   output logic [7:0]            green,
   output logic [7:0]            blue,
   output logic [7:0]            alpha,
   output logic [7:0]            repeat_count,
   output logic                  image_done
);
   localparam int QD = tga_pkg::QUEUE_DEPTH;
   localparam int AW = tga_pkg::PAL_AW;

   logic [23:0] pal_rd;
   logic        in_range;
   logic        st_valid_ff;
   logic        st_range_ff;
   tga_pkg::pix_word_type st_word_ff;
   logic [40:0] q_ff [QD];
   logic [40:0] q_in;
   logic        rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [2:0]  occ;
   logic [7:0]  r, g, b, a;
   logic [31:0] by;
   logic [15:0] c;
   logic        do_pop;

   assign in_range = ({1'b0, pix_word.bytes[7:0]} < 9'(tga_pkg::PALETTE_DEPTH));

   tga_ram #(.WIDTH(24), .DEPTH(tga_pkg::PALETTE_DEPTH)) u_palette (
      .clock   (clock),
      .wr_en   (pal_we && ({1'b0, pal_index} < 9'(tga_pkg::PALETTE_DEPTH))),
      .wr_addr (pal_index[AW-1:0]),
      .wr_data (pal_data),
      .rd_en   (pix_valid),
      .rd_addr (pix_word.bytes[AW-1:0]),
      .rd_data (pal_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) st_valid_ff <= 1'b0;
      else       st_valid_ff <= pix_valid;
      if (pix_valid) begin
         st_word_ff  <= pix_word;
         st_range_ff <= in_range;
      end
   end

   always_comb begin
      by = st_word_ff.bytes;
      c  = by[15:0];
      r = by[23:16]; g = by[15:8]; b = by[7:0]; a = 8'd255;
      case (st_word_ff.fmt)
         tga_pkg::FMT_INDEX8: begin
            if (st_range_ff) begin
               r = pal_rd[23:16]; g = pal_rd[15:8]; b = pal_rd[7:0];
            end else begin
               r = 8'd0; g = 8'd0; b = 8'd0;
            end
         end
         tga_pkg::FMT_RGB555: begin
            r = {c[14:10], 3'd0}; g = {c[9:5], 3'd0}; b = {c[4:0], 3'd0};
         end
         tga_pkg::FMT_BGRA32: a = by[31:24];
         tga_pkg::FMT_GRAY8: begin
            r = by[7:0]; g = 8'd0; b = 8'd0; a = 8'd0;
         end
         tga_pkg::FMT_GRAY16: begin
            r = by[7:0]; g = by[7:0]; b = by[7:0]; a = by[15:8];
         end
         default: ;
      endcase
      q_in = {r, g, b, a, st_word_ff.reps, st_word_ff.done};
   end

   assign empty  = (cnt_ff == 2'd0);
   assign do_pop = pop && !empty;
   // queue occupancy after this edge; one more word may follow the stage
   assign occ     = {1'b0, cnt_ff} + {2'b0, st_valid_ff} - {2'b0, do_pop};
   assign no_room = (occ >= 3'(QD));

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      wr_ptr_in = wr_ptr_ff ^ st_valid_ff;
      cnt_in    = cnt_ff + {1'b0, st_valid_ff} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0; wr_ptr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in; wr_ptr_ff <= wr_ptr_in; cnt_ff <= cnt_in;
      end
      if (st_valid_ff) q_ff[wr_ptr_ff] <= q_in;
   end

   assign {red, green, blue, alpha, repeat_count, image_done} = q_ff[rd_ptr_ff];
endmodule

// ===== design/tga_rle_pixel_decoder_core.sv =====
// Targa pixel-data decoder: takes one byte word (or palette write) per cycle
// while full is low and delivers RGBA pixels with a repeat count; sustained
// rate is one word a cycle while the consumer pops. A result passes through
// the registered palette read and then the two-entry result queue.
// full rises when the queue, after this cycle's pop, could not absorb the
// pixel in flight plus a new one, so full follows pop in the same cycle; the
// front end itself never stalls. Depends on tga_pkg, tga_front, tga_back and
// tga_ram.
`timescale 1ns / 1ps
module tga_rle_pixel_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_palette_red,
   input  logic [7:0]  req_palette_green,
   input  logic [7:0]  req_palette_blue,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_image_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [2:0]  fmt_ff;
   logic        rlc_ff;
   logic [31:0] total_ff;
   logic        csr_wr, restart, accept;
   logic        pix_valid;
   logic        no_room;
   tga_pkg::pix_word_type pix_word;

   // Register writes are always taken; known indexes restart the image.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;
   assign restart   = csr_wr && (csr_index == tga_pkg::REG_PIXEL_FORMAT ||
                      csr_index == tga_pkg::REG_RUN_LENGTH ||
                      csr_index == tga_pkg::REG_TOTAL_PIXELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= tga_pkg::FMT_BGR24; rlc_ff <= 1'b0; total_ff <= 32'd1;
      end else if (csr_wr) begin
         case (csr_index)
            tga_pkg::REG_PIXEL_FORMAT: fmt_ff   <= csr_data[2:0];
            tga_pkg::REG_RUN_LENGTH:   rlc_ff   <= csr_data[0];
            tga_pkg::REG_TOTAL_PIXELS: total_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Room needed for the pixel in the stage register and one more.
   assign full   = no_room;
   assign accept = push && !full;

   tga_front u_front (
      .clock, .reset,
      .byte_valid       (accept && req_type == tga_pkg::REQ_STREAM),
      .byte_data        (req_stream_byte),
      .pixel_format     (fmt_ff),
      .run_length_coded (rlc_ff),
      .total_pixels     (total_ff),
      .restart          (restart),
      .pix_valid        (pix_valid),
      .pix_word         (pix_word)
   );

   tga_back u_back (
      .clock, .reset,
      .pix_valid    (pix_valid),
      .pix_word     (pix_word),
      .pal_we       (accept && req_type == tga_pkg::REQ_PALETTE),
      .pal_index    (req_palette_index),
      .pal_data     ({req_palette_red, req_palette_green, req_palette_blue}),
      .pop          (pop),
      .empty        (empty),
      .no_room      (no_room),
      .red          (rsp_red),
      .green        (rsp_green),
      .blue         (rsp_blue),
      .alpha        (rsp_alpha),
      .repeat_count (rsp_repeat_count),
      .image_done   (rsp_image_done)
   );
endmodule
